[rtl/core/ipsvm_pkg.sv]
package ipsvm_pkg;

  // Fixed-point format and sine table size. The table depth must be a power of two.
  localparam int FRAC_BITS        = 24;
  localparam int SINE_TABLE_DEPTH = 256;

  // Derived widths for the quarter-wave lookup.
  localparam int QSHIFT     = FRAC_BITS - 2;
  localparam int LOG2_DEPTH = $clog2(SINE_TABLE_DEPTH);
  localparam int FINE_W     = QSHIFT - LOG2_DEPTH;
  localparam int IDX_W      = LOG2_DEPTH + 1;
  localparam int POS_W      = QSHIFT + 1;
  localparam int TAB_W      = FRAC_BITS + 1;
  localparam int TRIG_W     = FRAC_BITS + 2;

  // Pipeline layout: sine/cosine, rotation, then duty generation.
  localparam int SC_STAGES  = 4;
  localparam int ROT_STAGES = 3;
  localparam int PWM_STAGES = 3;
  localparam int NUM_STAGES = SC_STAGES + ROT_STAGES + PWM_STAGES;

  // One in the output format, and sqrt(3)/2 rounded down.
  localparam logic [31:0]        ONE            = 32'd1 << FRAC_BITS;
  localparam logic [63:0]        SQRT3_HALF_Q32 = 64'd3719550786;
  localparam logic signed [31:0] K3             = 32'(SQRT3_HALF_Q32 >> (32 - FRAC_BITS));

  // Constants for building the sine table from a Taylor series in Q30.
  localparam longint PI_HALF_Q30 = 64'sd1686629713;
  localparam longint TAYLOR_DIV [12] = '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420, 506, 600};
  localparam int     ROUND_SH = (FRAC_BITS >= 30) ? 0 : 29 - FRAC_BITS;

  typedef logic [TAB_W-1:0] sine_tab_t [0:SINE_TABLE_DEPTH];

  // Quarter-wave sine table, evaluated at elaboration.
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    longint    x;
    longint    x2;
    longint    term;
    longint    sum;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x    = (PI_HALF_Q30 * longint'(k)) / SINE_TABLE_DEPTH;
      x2   = (x * x) >>> 30;
      term = x;
      sum  = x;
      for (int n = 1; n <= 12; n++) begin
        term = ((term * x2) >>> 30) / TAYLOR_DIV[n-1];
        if ((n % 2) == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      if (30 - FRAC_BITS > 0) begin
        sum = (sum + (64'sd1 <<< ROUND_SH)) >>> (30 - FRAC_BITS);
      end
      tab[k] = TAB_W'(sum);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  // Sector code: bit 0 set when Va > 0, bit 1 when Vb > 0, bit 2 when Vc > 0.
  typedef enum logic [2:0] {
    SEC_NONE = 3'd0,
    SEC_A    = 3'd1,
    SEC_B    = 3'd2,
    SEC_AB   = 3'd3,
    SEC_C    = 3'd4,
    SEC_AC   = 3'd5,
    SEC_BC   = 3'd6,
    SEC_ABC  = 3'd7
  } sector_t;

  // Input item.
  typedef struct packed {
    logic signed [31:0] angle_pu;
    logic signed [31:0] d_command;
    logic signed [31:0] q_command;
  } cmd_t;

  // Result item.
  typedef struct packed {
    logic signed [31:0] phase_a_duty;
    logic signed [31:0] phase_b_duty;
    logic signed [31:0] phase_c_duty;
  } duty_t;

  // Between the sine/cosine unit and the rotation.
  typedef struct packed {
    logic signed [31:0]       d_command;
    logic signed [31:0]       q_command;
    logic signed [TRIG_W-1:0] sin_val;
    logic signed [TRIG_W-1:0] cos_val;
  } trig_t;

  // Between the rotation and the duty generator.
  typedef struct packed {
    logic signed [31:0] ka;
    logic signed [31:0] kb;
    logic signed [31:0] beta;
  } axis_t;

endpackage

[rtl/core/ipsvm_pipe_ctrl.sv]
module ipsvm_pipe_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ipsvm_pkg::NUM_STAGES-1:0] en
);

  localparam int N = ipsvm_pkg::NUM_STAGES;

  logic [N-1:0] valid;
  logic [N-1:0] valid_next;
  logic [N-1:0] ready;
  logic [N-1:0] upstream;

  // A stage may load when it is empty or when the stage after it moves on.
  always_comb begin
    ready[N-1] = !valid[N-1] || out_ready;
    for (int i = N - 2; i >= 0; i--) begin
      ready[i] = !valid[i] || ready[i+1];
    end
  end

  // Each valid bit follows its item down the pipe.
  assign upstream   = {valid[N-2:0], in_valid};
  assign valid_next = (ready & upstream) | (~ready & valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

  assign en        = ready;
  assign in_ready  = ready[0];
  assign out_valid = valid[N-1];

endmodule

[rtl/core/ipsvm_sincos.sv]
module ipsvm_sincos (
  input  logic                            clk,
  input  logic [ipsvm_pkg::SC_STAGES-1:0] en,
  input  ipsvm_pkg::cmd_t                 cmd,
  output ipsvm_pkg::trig_t                trig
);

  localparam int FB     = ipsvm_pkg::FRAC_BITS;
  localparam int QS     = ipsvm_pkg::QSHIFT;
  localparam int POS_W  = ipsvm_pkg::POS_W;
  localparam int FINE_W = ipsvm_pkg::FINE_W;
  localparam int IDX_W  = ipsvm_pkg::IDX_W;
  localparam int TAB_W  = ipsvm_pkg::TAB_W;
  localparam int TW     = ipsvm_pkg::TRIG_W;
  localparam int PROD_W = TAB_W + FINE_W + 2;

  // Lane 0 carries the sine, lane 1 the cosine (a quarter turn ahead).
  logic [1:0]       quad [2];
  logic [POS_W-1:0] pos  [2];
  logic [POS_W-1:0] r_fwd;
  logic [POS_W-1:0] r_rev;

  // Stage 1 registers.
  logic [IDX_W-1:0]  lo_idx [2];
  logic [IDX_W-1:0]  hi_idx [2];
  logic [FINE_W-1:0] fine1  [2];
  logic              neg1   [2];
  logic signed [31:0] d1, q1;

  // Stage 2 registers.
  logic [TAB_W-1:0]        lo2   [2];
  logic signed [TAB_W:0]   diff2 [2];
  logic [FINE_W-1:0]       fine2 [2];
  logic                    neg2  [2];
  logic signed [31:0]      d2, q2;

  // Stage 3 registers.
  logic signed [PROD_W-1:0] prod  [2];
  logic [TAB_W-1:0]         lo3   [2];
  logic signed [TAB_W:0]    corr3 [2];
  logic                     neg3  [2];
  logic signed [31:0]       d3, q3;

  logic signed [TW-1:0] mag [2];
  logic signed [TW-1:0] val [2];

  // Fold the angle into the first quadrant for both lanes.
  always_comb begin
    quad[0] = cmd.angle_pu[FB-1:QS];
    quad[1] = quad[0] + 2'd1;
    r_fwd   = {1'b0, cmd.angle_pu[QS-1:0]};
    r_rev   = (POS_W'(1) << QS) - r_fwd;
    for (int l = 0; l < 2; l++) begin
      pos[l] = quad[l][0] ? r_rev : r_fwd;
    end
  end

  // Stage 1: table index pair and interpolation fraction.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int l = 0; l < 2; l++) begin
        lo_idx[l] <= pos[l][POS_W-1:FINE_W];
        hi_idx[l] <= (pos[l][POS_W-1:FINE_W] == IDX_W'(ipsvm_pkg::SINE_TABLE_DEPTH)) ?
                     pos[l][POS_W-1:FINE_W] : pos[l][POS_W-1:FINE_W] + IDX_W'(1);
        fine1[l]  <= pos[l][FINE_W-1:0];
        neg1[l]   <= quad[l][1];
      end
      d1 <= cmd.d_command;
      q1 <= cmd.q_command;
    end
  end

  // Stage 2: table reads and the slope between neighboring points.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int l = 0; l < 2; l++) begin
        lo2[l]   <= ipsvm_pkg::SINE_TAB[lo_idx[l]];
        diff2[l] <= $signed({1'b0, ipsvm_pkg::SINE_TAB[hi_idx[l]]}) -
                    $signed({1'b0, ipsvm_pkg::SINE_TAB[lo_idx[l]]});
        fine2[l] <= fine1[l];
        neg2[l]  <= neg1[l];
      end
      d2 <= d1;
      q2 <= q1;
    end
  end

  // Stage 3: slope times fraction, floored.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      prod[l] = PROD_W'(diff2[l]) * PROD_W'($signed({1'b0, fine2[l]}));
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int l = 0; l < 2; l++) begin
        lo3[l]   <= lo2[l];
        corr3[l] <= (TAB_W + 1)'(prod[l] >>> FINE_W);
        neg3[l]  <= neg2[l];
      end
      d3 <= d2;
      q3 <= q2;
    end
  end

  // Stage 4: add the correction and apply the quadrant sign.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      mag[l] = $signed({1'b0, lo3[l]}) + TW'(corr3[l]);
      val[l] = neg3[l] ? -mag[l] : mag[l];
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      trig.sin_val   <= val[0];
      trig.cos_val   <= val[1];
      trig.d_command <= d3;
      trig.q_command <= q3;
    end
  end

endmodule

[rtl/core/ipsvm_rotate.sv]
module ipsvm_rotate (
  input  logic                             clk,
  input  logic [ipsvm_pkg::ROT_STAGES-1:0] en,
  input  ipsvm_pkg::trig_t                 trig,
  output ipsvm_pkg::axis_t                 axis
);

  localparam int FB = ipsvm_pkg::FRAC_BITS;
  localparam int PW = 32 + ipsvm_pkg::TRIG_W;

  logic signed [PW-1:0] p_dc, p_qs, p_qc, p_ds;
  logic signed [63:0]   p_ka;

  // Stage 5 registers: the four rotation products in Q format.
  logic signed [31:0] dc, qs, qc, ds;
  // Stage 6 registers.
  logic signed [31:0] alpha, beta;

  // Stage 5: d*cos, q*sin, q*cos, d*sin, each floored and wrapped to 32 bits.
  always_comb begin
    p_dc = PW'(trig.d_command) * PW'(trig.cos_val);
    p_qs = PW'(trig.q_command) * PW'(trig.sin_val);
    p_qc = PW'(trig.q_command) * PW'(trig.cos_val);
    p_ds = PW'(trig.d_command) * PW'(trig.sin_val);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dc <= p_dc[FB+31:FB];
      qs <= p_qs[FB+31:FB];
      qc <= p_qc[FB+31:FB];
      ds <= p_ds[FB+31:FB];
    end
  end

  // Stage 6: inverse Park rotation.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      alpha <= dc - qs;
      beta  <= qc + ds;
    end
  end

  // Stage 7: scale alpha by sqrt(3)/2 and halve beta.
  assign p_ka = 64'(alpha) * 64'(ipsvm_pkg::K3);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      axis.ka   <= p_ka[FB+31:FB];
      axis.kb   <= beta >>> 1;
      axis.beta <= beta;
    end
  end

endmodule

[rtl/core/ipsvm_svpwm.sv]
module ipsvm_svpwm (
  input  logic                             clk,
  input  logic [ipsvm_pkg::PWM_STAGES-1:0] en,
  input  ipsvm_pkg::axis_t                 axis,
  output ipsvm_pkg::duty_t                 duty
);

  logic signed [31:0] vb, vc;
  logic [31:0]        base_next;
  logic [31:0]        ta, tb, tc;

  // Stage 8 registers.
  ipsvm_pkg::sector_t sector8;
  logic [31:0]        a8, b8, c8;
  // Stage 9 registers.
  ipsvm_pkg::sector_t sector9;
  logic [31:0]        a9, b9, c9;
  logic [31:0]        base9;

  // Stage 8: reference voltages and the sector from their signs.
  assign vb = axis.ka - axis.kb;
  assign vc = -axis.ka - axis.kb;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sector8 <= ipsvm_pkg::sector_t'({vc > 0, vb > 0, axis.beta > 0});
      a8      <= axis.beta;
      b8      <= axis.ka + axis.kb;
      c8      <= axis.kb - axis.ka;
    end
  end

  // Stage 9: the first duty of each sector, halved with a floor.
  always_comb begin
    unique case (sector8)
      ipsvm_pkg::SEC_A:  base_next = 32'($signed(ipsvm_pkg::ONE - c8 - b8) >>> 1);
      ipsvm_pkg::SEC_B:  base_next = 32'($signed(ipsvm_pkg::ONE - b8 + a8) >>> 1);
      ipsvm_pkg::SEC_AB: base_next = 32'($signed(ipsvm_pkg::ONE + c8 - a8) >>> 1);
      ipsvm_pkg::SEC_C:  base_next = 32'($signed(ipsvm_pkg::ONE + a8 - c8) >>> 1);
      ipsvm_pkg::SEC_AC: base_next = 32'($signed(ipsvm_pkg::ONE - a8 + b8) >>> 1);
      ipsvm_pkg::SEC_BC: base_next = 32'($signed(ipsvm_pkg::ONE + b8 + c8) >>> 1);
      default:           base_next = ipsvm_pkg::ONE >> 1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sector9 <= sector8;
      a9      <= a8;
      b9      <= b8;
      c9      <= c8;
      base9   <= base_next;
    end
  end

  // Stage 10: the other two duties follow from the first.
  always_comb begin
    unique case (sector9)
      ipsvm_pkg::SEC_A: begin
        tb = base9;
        ta = base9 + c9;
        tc = ta + b9;
      end
      ipsvm_pkg::SEC_B: begin
        ta = base9;
        tc = base9 + b9;
        tb = tc - a9;
      end
      ipsvm_pkg::SEC_AB: begin
        ta = base9;
        tb = base9 - c9;
        tc = tb + a9;
      end
      ipsvm_pkg::SEC_C: begin
        tc = base9;
        tb = base9 - a9;
        ta = tb + c9;
      end
      ipsvm_pkg::SEC_AC: begin
        tb = base9;
        tc = base9 + a9;
        ta = tc - b9;
      end
      ipsvm_pkg::SEC_BC: begin
        tc = base9;
        ta = base9 - b9;
        tb = ta - c9;
      end
      default: begin
        ta = base9;
        tb = base9;
        tc = base9;
      end
    endcase
  end

  // Map each duty T to 1 - 2T.
  always_ff @(posedge clk) begin
    if (en[2]) begin
      duty.phase_a_duty <= ipsvm_pkg::ONE - (ta << 1);
      duty.phase_b_duty <= ipsvm_pkg::ONE - (tb << 1);
      duty.phase_c_duty <= ipsvm_pkg::ONE - (tc << 1);
    end
  end

endmodule

[rtl/core/inverse_park_space_vector_pwm_unit.sv]
// Channel  Direction  Handshake                Payload
// cmd      in         cmd_valid / cmd_ready    angle_pu, d_command, q_command
// duty     out        duty_valid / duty_ready  phase_a_duty, phase_b_duty, phase_c_duty
//
// One item enters per cycle while cmd_ready is high, through a 10-stage pipeline
// (4 sine/cosine, 3 rotation, 3 duty stages).
// Reset clears only the stage valid bits; the sine table is constant logic.
// A stage holds while it is full and the stage after it cannot load, so a stall
// on duty_ready first fills the empty stages; cmd_ready falls only when all ten
// stages hold an item.
module inverse_park_space_vector_pwm_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  ipsvm_pkg::cmd_t  cmd,
  output logic             duty_valid,
  input  logic             duty_ready,
  output ipsvm_pkg::duty_t duty
);

  localparam int SC  = ipsvm_pkg::SC_STAGES;
  localparam int ROT = ipsvm_pkg::ROT_STAGES;
  localparam int PWM = ipsvm_pkg::PWM_STAGES;

  logic [ipsvm_pkg::NUM_STAGES-1:0] en;
  ipsvm_pkg::trig_t                 trig;
  ipsvm_pkg::axis_t                 axis;

  // Valid bits and per-stage load enables.
  ipsvm_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd_valid),
    .in_ready  (cmd_ready),
    .out_valid (duty_valid),
    .out_ready (duty_ready),
    .en        (en)
  );

  // Sine and cosine by quarter-wave table with interpolation.
  ipsvm_sincos u_sincos (
    .clk  (clk),
    .en   (en[SC-1:0]),
    .cmd  (cmd),
    .trig (trig)
  );

  // Inverse Park rotation and reference scaling.
  ipsvm_rotate u_rotate (
    .clk  (clk),
    .en   (en[SC+ROT-1:SC]),
    .trig (trig),
    .axis (axis)
  );

  // Sector selection and duty computation.
  ipsvm_svpwm u_svpwm (
    .clk  (clk),
    .en   (en[SC+ROT+PWM-1:SC+ROT]),
    .axis (axis),
    .duty (duty)
  );

endmodule

[rtl/core/ipsvm_checker.sv]
module ipsvm_checker (
  input logic             clk,
  input logic             rst,
  input logic             cmd_valid,
  input logic             cmd_ready,
  input logic             duty_valid,
  input logic             duty_ready,
  input ipsvm_pkg::duty_t duty
);

  // Reset empties the pipeline.
  a_reset_empty : assert property (@(posedge clk) rst |=> !duty_valid && cmd_ready)
    else $error("pipeline not empty after reset");

  // The input side only stalls when the output holds an item that is not taken.
  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    !cmd_ready |-> duty_valid && !duty_ready)
    else $error("input stalled without an output stall");

  // A taken output slot always frees the input side.
  a_ready_flow : assert property (@(posedge clk) disable iff (rst)
    duty_ready |-> cmd_ready)
    else $error("input not ready while output is ready");

  // A waiting result holds.
  a_out_hold : assert property (@(posedge clk) disable iff (rst)
    duty_valid && !duty_ready |=> duty_valid && $stable(duty))
    else $error("result changed while stalled");

endmodule

bind inverse_park_space_vector_pwm_unit ipsvm_checker u_checker (.*);
